[rtl/fbld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbld_pkg: shared definitions of the MAC frame builder
// Constants, register indexes and the work entry passed from front to back.
// ----------------------------------------------------------------------------
package fbld_pkg;

	// Default sizing
	localparam int MAX_PAYLOAD_DEF = 104;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Command mode
	localparam logic [7:0] CMD_MARK = 8'h23;
	localparam logic [7:0] CMD_BYTE = 8'h53;
	localparam int         CMD_ARGS = 5;
	localparam int         PAD_W    = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_CONTROL  = 3'd0,
		REG_PAN_ID         = 3'd1,
		REG_DEST_ADDR_LOW  = 3'd2,
		REG_DEST_ADDR_HIGH = 3'd3,
		REG_SRC_ADDR_LOW   = 3'd4,
		REG_SRC_ADDR_HIGH  = 3'd5
	} cfg_reg_t;

	// Register reset values
	localparam logic [15:0] FRAME_CONTROL_RST  = 16'hCC61;
	localparam logic [15:0] PAN_ID_RST         = 16'h0417;
	localparam logic [31:0] DEST_ADDR_LOW_RST  = 32'h0000_0A63;
	localparam logic [31:0] DEST_ADDR_HIGH_RST = 32'h5743_5500;
	localparam logic [31:0] SRC_ADDR_LOW_RST   = 32'h0000_0417;
	localparam logic [31:0] SRC_ADDR_HIGH_RST  = 32'h4443_5500;

	// One classified input transaction
	typedef struct packed {
		logic [7:0]       data;  // byte to send (0x53 on a command start)
		logic             hdr;   // first byte of a message: header goes first
		logic             emit;  // data byte is sent
		logic             last;  // message ends: trailer (command) and FCS
		logic             cmd;   // message is in command mode
		logic [PAD_W-1:0] pad;   // zero bytes still owed in command mode
		logic             ovf;   // payload bytes were dropped in this frame
	} entry_t;

endpackage

[rtl/mac_frame_builder_with_fcs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_frame_builder_with_fcs: 802.15.4 data frame builder with CRC-16 FCS
// Payload bytes in, framed bytes with header, optional command trailer and
// FCS out, both sides as queues.
// ----------------------------------------------------------------------------
// Push payload bytes with last set on the final byte of a message; pop frame
// bytes while empty is low. The frame sequencer sends one byte per cycle while
// its two-entry output buffer has room; the first byte of a message is preceded
// by the 21 header bytes, and the final byte adds the 2 FCS bytes; in
// command mode the final byte also adds up to 5 padding bytes and an 18-byte
// trailer. A work queue of QUEUE_DEPTH entries lets input keep flowing while
// these bursts are sent; full rises when it fills. Configuration writes take
// effect at once and are meant for times when no frame is in flight.
// ----------------------------------------------------------------------------
module mac_frame_builder_with_fcs #(
	parameter int MAX_PAYLOAD = fbld_pkg::MAX_PAYLOAD_DEF,
	parameter int QUEUE_DEPTH = fbld_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [fbld_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbld_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            push,
	output logic                            full,
	input  logic [7:0]                      data_byte,
	input  logic                            last,
	output logic                            empty,
	input  logic                            pop,
	output logic [7:0]                      frame_byte,
	output logic                            frame_last,
	output logic                            truncated
);

	logic             accept;
	logic             q_enq;
	fbld_pkg::entry_t q_enq_entry;
	logic             q_deq;
	logic             q_full;
	logic             q_head_valid;
	fbld_pkg::entry_t q_head;

	assign full   = q_full;
	assign accept = push && !q_full;

	fbld_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last      (last),
		.enq       (q_enq),
		.enq_entry (q_enq_entry)
	);

	fbld_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.enq        (q_enq),
		.enq_entry  (q_enq_entry),
		.deq        (q_deq),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head_entry (q_head)
	);

	fbld_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.head_valid (q_head_valid),
		.head_entry (q_head),
		.deq        (q_deq),
		.pop        (pop),
		.empty      (empty),
		.frame_byte (frame_byte),
		.frame_last (frame_last),
		.truncated  (truncated)
	);

	// Work queue never written while full
	a_enq_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_enq |-> !q_full)
		else $error("work queue written while full");

	// Back end retires only entries that exist
	a_deq_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_deq |-> q_head_valid)
		else $error("work queue read while empty");

	// Every retired entry produced at least one byte
	a_deq_useful: assert property (@(posedge clk) disable iff (!arst_n)
		q_deq |-> (q_head.emit || q_head.last))
		else $error("work entry without effect reached the back end");

endmodule

[rtl/fbld_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbld_front: input classification
// Tracks message state per accepted byte and turns each byte into a work
// entry for the back end. Dropped bytes that do not end a message vanish here.
// ----------------------------------------------------------------------------
module fbld_front #(
	parameter int MAX_PAYLOAD = fbld_pkg::MAX_PAYLOAD_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             last,
	output logic             enq,
	output fbld_pkg::entry_t enq_entry
);

	localparam int CW = $clog2(MAX_PAYLOAD + 1);

	logic          in_frame_q;
	logic          cmd_q;
	logic          ovf_q;
	logic [CW-1:0] cnt_q;

	logic          is_mark;
	logic          emit;
	logic          cmd_n;
	logic          ovf_n;
	logic [CW-1:0] cnt_n;

	// Classify the byte against the current message state
	always_comb begin
		is_mark = (data_byte == fbld_pkg::CMD_MARK);
		emit    = 1'b0;
		cmd_n   = cmd_q;
		ovf_n   = ovf_q;
		cnt_n   = cnt_q;
		if (!in_frame_q) begin
			emit  = 1'b1;
			cmd_n = is_mark;
			ovf_n = 1'b0;
			cnt_n = is_mark ? '0 : CW'(1);
		end else if (cmd_q) begin
			if (cnt_q < CW'(fbld_pkg::CMD_ARGS)) begin
				emit  = 1'b1;
				cnt_n = cnt_q + CW'(1);
			end
		end else if (cnt_q < CW'(MAX_PAYLOAD)) begin
			emit  = 1'b1;
			cnt_n = cnt_q + CW'(1);
		end else begin
			ovf_n = 1'b1;
		end

		enq_entry.data = (!in_frame_q && is_mark) ? fbld_pkg::CMD_BYTE : data_byte;
		enq_entry.hdr  = !in_frame_q;
		enq_entry.emit = emit;
		enq_entry.last = last;
		enq_entry.cmd  = cmd_n;
		enq_entry.ovf  = ovf_n;
		enq_entry.pad  = cmd_n ?
			(fbld_pkg::PAD_W'(fbld_pkg::CMD_ARGS) - cnt_n[fbld_pkg::PAD_W-1:0]) : '0;
	end

	assign enq = accept && (emit || last);

	// Message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			cmd_q      <= 1'b0;
			ovf_q      <= 1'b0;
			cnt_q      <= '0;
		end else if (accept) begin
			if (last) begin
				in_frame_q <= 1'b0;
				cmd_q      <= 1'b0;
				ovf_q      <= 1'b0;
				cnt_q      <= '0;
			end else begin
				in_frame_q <= 1'b1;
				cmd_q      <= cmd_n;
				ovf_q      <= ovf_n;
				cnt_q      <= cnt_n;
			end
		end
	end

endmodule

[rtl/fbld_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbld_queue: work queue between front and back
// Small circular buffer of work entries; head is read directly.
// ----------------------------------------------------------------------------
module fbld_queue #(
	parameter int DEPTH = fbld_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             enq,
	input  fbld_pkg::entry_t enq_entry,
	input  logic             deq,
	output logic             full,
	output logic             head_valid,
	output fbld_pkg::entry_t head_entry
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	fbld_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_entry = mem_q[rp_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wp_q] <= enq_entry;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (deq) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[rtl/fbld_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbld_back: frame byte sequencer
// Holds the configuration registers, walks each work entry through header,
// body, padding, trailer and FCS phases at one byte per cycle while its two-entry
// output queue has room, and keeps the running CRC and sequence number.
// ----------------------------------------------------------------------------
module fbld_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [fbld_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fbld_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                head_valid,
	input  fbld_pkg::entry_t                    head_entry,
	output logic                                deq,
	input  logic                                pop,
	output logic                                empty,
	output logic [7:0]                          frame_byte,
	output logic                                frame_last,
	output logic                                truncated
);

	localparam int          HDR_LEN  = 21;
	localparam int          TRL_LEN  = 18;
	localparam int          SEQ_POS  = 2;
	localparam logic [15:0] CRC_POLY = 16'h8408;

	typedef enum logic [5:0] {
		PH_HDR  = 6'b000001,
		PH_BODY = 6'b000010,
		PH_PAD  = 6'b000100,
		PH_TRL  = 6'b001000,
		PH_FCS0 = 6'b010000,
		PH_FCS1 = 6'b100000
	} phase_t;

	// CRC-16/KERMIT, one byte, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	logic [15:0] fc_q;
	logic [15:0] pan_q;
	logic [31:0] dlo_q;
	logic [31:0] dhi_q;
	logic [31:0] slo_q;
	logic [31:0] shi_q;

	logic [7:0]  seq_q;
	logic [15:0] crc_q;
	logic        fresh_q;
	phase_t      ph_q;
	logic [4:0]  idx_q;

	logic [7:0]  ob_data_q  [2];
	logic        ob_last_q  [2];
	logic        ob_trunc_q [2];
	logic        ob_wp_q;
	logic        ob_rp_q;
	logic [1:0]  ob_cnt_q;

	logic [7:0]  hdr_b [HDR_LEN];
	logic [7:0]  trl_b [TRL_LEN];

	phase_t      first_ph;
	phase_t      tail_ph;
	logic        tail_done;
	phase_t      eff_ph;
	logic [4:0]  eff_idx;
	phase_t      nxt_ph;
	logic [4:0]  nxt_idx;
	logic        done;
	logic        step;
	logic        crc_upd;
	logic [7:0]  o_byte;
	logic        o_last;
	logic        o_trunc;
	logic        rd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q  <= fbld_pkg::FRAME_CONTROL_RST;
			pan_q <= fbld_pkg::PAN_ID_RST;
			dlo_q <= fbld_pkg::DEST_ADDR_LOW_RST;
			dhi_q <= fbld_pkg::DEST_ADDR_HIGH_RST;
			slo_q <= fbld_pkg::SRC_ADDR_LOW_RST;
			shi_q <= fbld_pkg::SRC_ADDR_HIGH_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fbld_pkg::REG_FRAME_CONTROL:  fc_q  <= cfg_wdata[15:0];
				fbld_pkg::REG_PAN_ID:         pan_q <= cfg_wdata[15:0];
				fbld_pkg::REG_DEST_ADDR_LOW:  dlo_q <= cfg_wdata;
				fbld_pkg::REG_DEST_ADDR_HIGH: dhi_q <= cfg_wdata;
				fbld_pkg::REG_SRC_ADDR_LOW:   slo_q <= cfg_wdata;
				fbld_pkg::REG_SRC_ADDR_HIGH:  shi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Header and trailer byte maps, low byte first (PAN ID high byte first in the trailer)
	always_comb begin
		hdr_b[0] = fc_q[7:0];
		hdr_b[1] = fc_q[15:8];
		hdr_b[2] = seq_q;
		hdr_b[3] = pan_q[7:0];
		hdr_b[4] = pan_q[15:8];
		for (int i = 0; i < 4; i++) begin
			hdr_b[5 + i]  = dlo_q[8*i +: 8];
			hdr_b[9 + i]  = dhi_q[8*i +: 8];
			hdr_b[13 + i] = slo_q[8*i +: 8];
			hdr_b[17 + i] = shi_q[8*i +: 8];
			trl_b[i]      = slo_q[8*i +: 8];
			trl_b[4 + i]  = shi_q[8*i +: 8];
			trl_b[8 + i]  = dlo_q[8*i +: 8];
			trl_b[12 + i] = dhi_q[8*i +: 8];
		end
		trl_b[16] = pan_q[15:8];
		trl_b[17] = pan_q[7:0];
	end

	// What follows the body byte of the head entry
	always_comb begin
		tail_ph   = PH_FCS0;
		tail_done = 1'b0;
		if (!head_entry.last) begin
			tail_done = 1'b1;
		end else if (head_entry.cmd) begin
			tail_ph = (head_entry.pad != '0) ? PH_PAD : PH_TRL;
		end
	end

	// Starting phase of a new head entry
	always_comb begin
		if (head_entry.hdr) begin
			first_ph = PH_HDR;
		end else if (head_entry.emit) begin
			first_ph = PH_BODY;
		end else begin
			first_ph = tail_ph;
		end
	end

	assign eff_ph  = fresh_q ? first_ph : ph_q;
	assign eff_idx = fresh_q ? '0 : idx_q;
	assign step    = head_valid && (ob_cnt_q != 2'd2);
	assign deq     = step && done;

	// Byte selection and phase sequencing
	always_comb begin
		o_byte  = 8'h00;
		o_last  = 1'b0;
		o_trunc = 1'b0;
		crc_upd = 1'b0;
		done    = 1'b0;
		nxt_ph  = eff_ph;
		nxt_idx = eff_idx + 5'd1;
		unique case (eff_ph)
			PH_HDR: begin
				o_byte  = hdr_b[eff_idx];
				crc_upd = 1'b1;
				if (eff_idx == 5'(HDR_LEN - 1)) begin
					nxt_ph  = PH_BODY;
					nxt_idx = '0;
				end
			end
			PH_BODY: begin
				o_byte  = head_entry.data;
				crc_upd = 1'b1;
				nxt_ph  = tail_ph;
				nxt_idx = '0;
				done    = tail_done;
			end
			PH_PAD: begin
				crc_upd = 1'b1;
				if ((eff_idx[fbld_pkg::PAD_W-1:0] + fbld_pkg::PAD_W'(1)) == head_entry.pad) begin
					nxt_ph  = PH_TRL;
					nxt_idx = '0;
				end
			end
			PH_TRL: begin
				o_byte  = trl_b[eff_idx];
				crc_upd = 1'b1;
				if (eff_idx == 5'(TRL_LEN - 1)) begin
					nxt_ph  = PH_FCS0;
					nxt_idx = '0;
				end
			end
			PH_FCS0: begin
				o_byte  = crc_q[7:0];
				o_trunc = head_entry.ovf;
				nxt_ph  = PH_FCS1;
			end
			PH_FCS1: begin
				o_byte  = crc_q[15:8];
				o_last  = 1'b1;
				o_trunc = head_entry.ovf;
				done    = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	// Sequencer state, CRC and sequence number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= '0;
			crc_q   <= '0;
			fresh_q <= 1'b1;
			ph_q    <= PH_HDR;
			idx_q   <= '0;
		end else if (step) begin
			if (eff_ph == PH_FCS1) begin
				crc_q <= '0;
			end else if (crc_upd) begin
				crc_q <= crc_byte(crc_q, o_byte);
			end
			if (eff_ph == PH_HDR && eff_idx == 5'(SEQ_POS)) begin
				seq_q <= seq_q + 8'd1;
			end
			if (done) begin
				fresh_q <= 1'b1;
			end else begin
				fresh_q <= 1'b0;
				ph_q    <= nxt_ph;
				idx_q   <= nxt_idx;
			end
		end
	end

	// Output buffer, two entries
	assign rd         = pop && !empty;
	assign empty      = (ob_cnt_q == 2'd0);
	assign frame_byte = ob_data_q[ob_rp_q];
	assign frame_last = ob_last_q[ob_rp_q];
	assign truncated  = ob_trunc_q[ob_rp_q];

	always_ff @(posedge clk) begin
		if (step) begin
			ob_data_q[ob_wp_q]  <= o_byte;
			ob_last_q[ob_wp_q]  <= o_last;
			ob_trunc_q[ob_wp_q] <= o_trunc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wp_q  <= 1'b0;
			ob_rp_q  <= 1'b0;
			ob_cnt_q <= '0;
		end else begin
			if (step) begin
				ob_wp_q <= !ob_wp_q;
			end
			if (rd) begin
				ob_rp_q <= !ob_rp_q;
			end
			if (step && !rd) begin
				ob_cnt_q <= ob_cnt_q + 2'd1;
			end else if (rd && !step) begin
				ob_cnt_q <= ob_cnt_q - 2'd1;
			end
		end
	end

endmodule
